FILE: sv/fbfl_pkg.sv
// Shared definitions for the fixed-block free-list allocator.
// Holds port widths, request, status and register codes, and the controller state type.
// No dependencies.
package fbfl_pkg;

   localparam int DEF_MAX_BLOCKS  = 256;
   localparam int DEF_ALIGN_BYTES = 8;
   localparam int HEADER_BYTES    = 8;

   localparam int REQ_W      = 2;
   localparam int INDEX_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int OFFSET_W   = 21;
   localparam int COUNT_W    = 9;
   localparam int BBYTES_W   = 13;
   localparam int NBLOCKS_W  = 9;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;

   // The block size plus the rounding term stays below 2**14, and so does the stride.
   localparam int ROUND_W  = 14;
   localparam int STRIDE_W = 14;

   typedef enum logic [REQ_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_FREE  = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_BYTES = 1'd0,
      CSR_NUM_BLOCKS  = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INIT
   } fsm_state_type;

endpackage

FILE: sv/fbfl_link_ram.sv
// Next-free link memory: one write port and one read port with registered read data.
// Depends on nothing; depth and widths come from the instantiating module.
module fbfl_link_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] link_mem_ff [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= link_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/fbfl_csr.sv
// Configuration registers: block count, and the block stride rounded up to the alignment.
// Uses fbfl_pkg; the rounding divides by a reciprocal constant, then scales over a second stage.
module fbfl_csr
   import fbfl_pkg::*;
#(
   parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [STRIDE_W-1:0]   stride,
   output logic [NBLOCKS_W-1:0]  num_blocks
);

   localparam int ALIGN_W = $clog2(ALIGN_BYTES) + 1;
   localparam int SHIFT   = ROUND_W + ALIGN_W;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = ROUND_W + RECIP_W;
   localparam int SCALE_W = STRIDE_W + ALIGN_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((2 ** SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES);
   localparam logic [ALIGN_W-1:0] ALIGN_K = ALIGN_W'(ALIGN_BYTES);
   localparam logic [STRIDE_W-1:0] Q_RESET =
      STRIDE_W'((8 + ALIGN_BYTES - 1) / ALIGN_BYTES);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET =
      STRIDE_W'(((8 + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES);
   localparam logic [NBLOCKS_W-1:0] NBLOCKS_RESET = NBLOCKS_W'(256);

   logic [STRIDE_W-1:0]  quot_ff, quot_in;
   logic [STRIDE_W-1:0]  stride_ff, stride_in;
   logic [NBLOCKS_W-1:0] num_blocks_ff, num_blocks_in;
   logic [ROUND_W-1:0]   round_up;
   logic [PROD_W-1:0]    recip_prod;
   logic [SCALE_W-1:0]   scale_prod;

   always_comb begin
      round_up   = ROUND_W'(csr_wdata[BBYTES_W-1:0]) + ROUND_W'(ALIGN_BYTES - 1);
      recip_prod = PROD_W'(round_up) * PROD_W'(RECIP);
      scale_prod = SCALE_W'(quot_ff) * SCALE_W'(ALIGN_K);

      quot_in       = quot_ff;
      num_blocks_in = num_blocks_ff;
      stride_in     = scale_prod[STRIDE_W-1:0];
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BLOCK_BYTES: begin
               quot_in = recip_prod[SHIFT +: STRIDE_W];
            end
            CSR_NUM_BLOCKS: begin
               num_blocks_in = csr_wdata[NBLOCKS_W-1:0];
            end
            default: begin
               quot_in = quot_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff       <= Q_RESET;
         stride_ff     <= STRIDE_RESET;
         num_blocks_ff <= NBLOCKS_RESET;
      end else begin
         quot_ff       <= quot_in;
         stride_ff     <= stride_in;
         num_blocks_ff <= num_blocks_in;
      end
   end

   assign stride     = stride_ff;
   assign num_blocks = num_blocks_ff;

endmodule

FILE: sv/fixed_block_free_list_allocator_top.sv
// Fixed-block free-list allocator: alloc, free and no-operation transactions go through an execute
// state that registers the result; the link memory read limits the rate.
// An init transaction writes one link per cycle and answers once the last of the n blocks is linked.
// A new transaction is accepted only while no result is waiting to be taken.
// Reset empties the free list, zeroes the free count and loads block size 8 and 256 blocks.
// The link memory is not cleared by reset; init writes it. Uses fbfl_pkg, fbfl_csr, fbfl_link_ram.
module fixed_block_free_list_allocator_top
   import fbfl_pkg::*;
#(
   parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
   parameter int ALIGN_BYTES = DEF_ALIGN_BYTES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [INDEX_W-1:0]    req_block_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [INDEX_W-1:0]    rsp_alloc_index,
   output logic [OFFSET_W-1:0]   rsp_byte_offset,
   output logic [COUNT_W-1:0]    rsp_free_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LINK_W  = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W  = $clog2(MAX_BLOCKS);
   localparam int CMP_W   = (LINK_W > NBLOCKS_W) ? LINK_W : NBLOCKS_W;
   localparam int PROD_W  = ADDR_W + STRIDE_W;
   localparam int SUM_W   = (PROD_W + 1 > OFFSET_W) ? PROD_W + 1 : OFFSET_W;
   localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_BLOCKS);
   localparam logic [CMP_W-1:0]  MAX_WIDE = CMP_W'(MAX_BLOCKS);

   fsm_state_type state_ff, state_in;

   req_code_type          req_ff, req_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [LINK_W-1:0]     head_ff, head_in;
   logic [LINK_W-1:0]     free_ff, free_in;
   logic [ADDR_W-1:0]     init_cnt_ff, init_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [INDEX_W-1:0]    alloc_index_ff, alloc_index_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [STRIDE_W-1:0]   stride;
   logic [NBLOCKS_W-1:0]  num_blocks;
   logic [CMP_W-1:0]      nb_wide;
   logic [CMP_W-1:0]      n_wide;
   logic [CMP_W-1:0]      head_wide;
   logic [CMP_W-1:0]      index_wide;
   logic [CMP_W-1:0]      cnt_next_wide;
   logic [CMP_W-1:0]      free_next_wide;
   logic                  init_last;
   logic                  accept;
   logic                  finish;
   logic [PROD_W-1:0]     offset_prod;
   logic [SUM_W-1:0]      offset_sum;

   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [LINK_W-1:0]     mem_wr_data;
   logic [LINK_W-1:0]     mem_rd_data;

   fbfl_csr #(
      .ALIGN_BYTES (ALIGN_BYTES)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .stride     (stride),
      .num_blocks (num_blocks)
   );

   fbfl_link_ram #(
      .DEPTH  (MAX_BLOCKS),
      .ADDR_W (ADDR_W),
      .DATA_W (LINK_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (head_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   always_comb begin
      nb_wide       = CMP_W'(num_blocks);
      n_wide        = (nb_wide > MAX_WIDE) ? MAX_WIDE : nb_wide;
      head_wide     = CMP_W'(head_ff);
      index_wide    = CMP_W'(index_ff);
      cnt_next_wide = CMP_W'(init_cnt_ff) + CMP_W'(1);
      init_last     = (cnt_next_wide >= n_wide);
      offset_prod   = PROD_W'(head_ff[ADDR_W-1:0]) * PROD_W'(stride);
      offset_sum    = SUM_W'(offset_prod) + SUM_W'(HEADER_BYTES);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((req_ff == REQ_INIT) && (n_wide != '0)) begin
               state_in = ST_INIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            if (init_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_in         = req_ff;
      index_in       = index_ff;
      head_in        = head_ff;
      free_in        = free_ff;
      init_cnt_in    = init_cnt_ff;
      status_in      = status_ff;
      alloc_index_in = alloc_index_ff;
      offset_in      = offset_ff;
      finish         = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = init_cnt_ff;
      mem_wr_data    = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_code_type'(req_type);
               index_in = req_block_index;
            end
         end
         ST_EXEC: begin
            status_in      = STATUS_OK;
            alloc_index_in = '0;
            offset_in      = '0;
            case (req_ff)
               REQ_INIT: begin
                  init_cnt_in = '0;
                  if (n_wide == '0) begin
                     head_in = LIST_END;
                     free_in = '0;
                     finish  = 1'b1;
                  end
               end
               REQ_ALLOC: begin
                  finish = 1'b1;
                  if (head_ff >= LIST_END) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     alloc_index_in = head_wide[INDEX_W-1:0];
                     offset_in      = offset_sum[OFFSET_W-1:0];
                     head_in        = mem_rd_data;
                     if (free_ff != '0) begin
                        free_in = free_ff - LINK_W'(1);
                     end
                  end
               end
               REQ_FREE: begin
                  finish = 1'b1;
                  if (index_wide >= n_wide) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = index_wide[ADDR_W-1:0];
                     mem_wr_data = head_ff;
                     head_in     = index_wide[LINK_W-1:0];
                     if (free_ff < LIST_END) begin
                        free_in = free_ff + LINK_W'(1);
                     end
                  end
               end
               REQ_NOP: begin
                  finish = 1'b1;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = init_cnt_ff;
            mem_wr_data = init_last ? LIST_END : cnt_next_wide[LINK_W-1:0];
            init_cnt_in = cnt_next_wide[ADDR_W-1:0];
            if (init_last) begin
               head_in = '0;
               free_in = n_wide[LINK_W-1:0];
               finish  = 1'b1;
            end
         end
         default: begin
            finish = 1'b0;
         end
      endcase

      free_next_wide = CMP_W'(free_in);
      count_in       = finish ? free_next_wide[COUNT_W-1:0] : count_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= LIST_END;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      index_ff       <= index_in;
      init_cnt_ff    <= init_cnt_in;
      status_ff      <= status_in;
      alloc_index_ff <= alloc_index_in;
      offset_ff      <= offset_in;
      count_ff       <= count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_alloc_index = alloc_index_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_free_count  = count_ff;

endmodule
